/* hdl/dsq_pkg.sv */
// Package with shared types and constants of the delta sleep queue.
package dsq_pkg;

  localparam int MaxSleepersDef = 16;
  localparam int WakeLimit      = 16;
  localparam logic [15:0] TimeSliceReset = 16'd2;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SLEEP    = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_WOKEN    = 3'd0,
    KIND_TICK     = 3'd1,
    KIND_QUEUED   = 3'd2,
    KIND_IGNORED  = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_DISPATCH = 3'd5
  } kind_t;

  // One classified command handed from the front part to the back part.
  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  tid;
    logic [31:0] ticks;
    logic        allow;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_DEC,
    ST_WAKE,
    ST_STATUS,
    ST_SEARCH,
    ST_SHIFT,
    ST_REPLY
  } state_t;

endpackage

/* hdl/dsq_front.sv */
// Front part: accepts commands, drops unused codes and queues the rest.
module dsq_front
  import dsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  job_t       in_job,
  output logic       q_valid,
  input  logic       q_ready,
  output job_t       q_job
);

  // Two-entry queue.
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  // Unused command codes are taken and dropped without a result.
  assign push     = in_valid && in_ready && (in_job.cmd != CMD_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1)) else $error("count slip");

endmodule

/* hdl/dsq_back.sv */
// Back part: delta list store, slice counter and result sequencing.
module dsq_back
  import dsq_pkg::*;
#(
  parameter int MAX_SLEEPERS = MaxSleepersDef
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  job_t        q_job,
  input  logic [15:0] time_slice,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_tid,
  output logic        out_pre,
  output logic        out_last
);

  localparam int IW = $clog2(MAX_SLEEPERS);
  localparam int CW = $clog2(MAX_SLEEPERS + 1);
  localparam int WW = $clog2(WakeLimit + 1);

  // Entry storage, one read and one write port each cycle.
  logic [3:0]  ids_r [MAX_SLEEPERS];
  logic [31:0] dls_r [MAX_SLEEPERS];

  state_t      st_r, st_nxt;
  job_t        job_r, job_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0] slice_r, slice_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [CW-1:0] pos_r, ptr_r;
  logic [CW-1:0] pos_nxt, ptr_nxt;
  logic [WW-1:0] nwake_r, nwake_nxt;
  logic [3:0]  rd_id_r;
  logic [31:0] rd_dl_r;
  logic        rd_ok_r, rd_ok_nxt;
  logic [2:0]  okind_r, okind_nxt;
  logic [3:0]  otid_r, otid_nxt;
  logic        opre_r, olast_r, ovalid_r;
  logic        opre_nxt, olast_nxt, ovalid_nxt;

  // Read address and write port requests.
  logic [IW-1:0] raddr;
  logic          we;
  logic [IW-1:0] waddr;
  logic [3:0]    wid;
  logic [31:0]   wdl;
  logic [16:0]   slice_inc;

  assign out_valid = ovalid_r;
  assign out_kind  = okind_r;
  assign out_tid   = otid_r;
  assign out_pre   = opre_r;
  assign out_last  = olast_r;
  assign q_ready   = (st_r == ST_IDLE) && !ovalid_r;
  assign slice_inc = {1'b0, slice_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (we) begin
      ids_r[waddr] <= wid;
      dls_r[waddr] <= wdl;
    end
    rd_id_r <= ids_r[raddr];
    rd_dl_r <= dls_r[raddr];
  end

  // Sequencer next state and memory control.
  always_comb begin
    st_nxt = st_r;
    raddr  = '0;
    we     = 1'b0;
    waddr  = '0;
    wid    = '0;
    wdl    = '0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          unique case (q_job.cmd)
            CMD_TICK:  st_nxt = ST_TICK_DEC;
            CMD_SLEEP: st_nxt = (q_job.ticks == 32'd0 || cnt_r == CW'(MAX_SLEEPERS))
                                ? ST_REPLY : ST_SEARCH;
            default:   st_nxt = ST_REPLY;
          endcase
        end
      end
      ST_TICK_DEC: begin
        // Head is read; decrement it here if nonzero.
        if (rd_ok_r && cnt_r != '0 && rd_dl_r != 32'd0) begin
          we = 1'b1; waddr = '0; wid = rd_id_r; wdl = rd_dl_r - 32'd1;
        end
        st_nxt = ST_WAKE;
      end
      ST_WAKE: begin
        raddr = IW'(ptr_r);
        if (!ovalid_r || out_ready) begin
          if (rd_ok_r) begin
            if (cnt_r != '0 && rd_dl_r == 32'd0 && nwake_r != WW'(WakeLimit)) begin
              st_nxt = ST_WAKE;
            end else begin
              st_nxt = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        // Compact the store after wakeups, one entry at a time.
        raddr = IW'(ptr_r);
        if (rd_ok_r) begin
          if (pos_r + CW'(nwake_r) < CW'(MAX_SLEEPERS) &&
              pos_r < cnt_r) begin
            we = 1'b1; waddr = IW'(pos_r); wid = rd_id_r; wdl = rd_dl_r;
          end
          if (pos_r >= cnt_r) st_nxt = ST_STATUS;
        end
      end
      ST_STATUS: st_nxt = (!ovalid_r || out_ready) ? ST_IDLE : ST_STATUS;
      ST_SEARCH: begin
        raddr = IW'(ptr_r);
        if (rd_ok_r) begin
          if (ptr_r < cnt_r && rem_r > rd_dl_r) begin
            st_nxt = ST_SEARCH;
          end else begin
            if (ptr_r < cnt_r) begin
              we = 1'b1; waddr = IW'(ptr_r); wid = rd_id_r; wdl = rd_dl_r - rem_r;
            end
            st_nxt = ST_SHIFT;
          end
        end
      end
      ST_REPLY: st_nxt = (!ovalid_r || out_ready) ? ST_IDLE : ST_REPLY;
      default:  st_nxt = ST_IDLE;
    endcase
    // ST_SHIFT also serves sleep insertion: a sleep uses a
    // backward walk from the end of the list toward the insert position.
    if (st_r == ST_SHIFT && job_r.cmd == CMD_SLEEP) begin
      we = 1'b0;
      raddr = IW'(ptr_r - CW'(1));
      if (rd_ok_r) begin
        if (ptr_r > pos_r) begin
          we = 1'b1; waddr = IW'(ptr_r); wid = rd_id_r; wdl = rd_dl_r;
          st_nxt = ST_SHIFT;
        end else begin
          we = 1'b1; waddr = IW'(pos_r); wid = job_r.tid; wdl = rem_r;
          st_nxt = ST_REPLY;
        end
      end
    end
  end

  // Next values of the walk registers, the slice counter and the result.
  always_comb begin
    cnt_nxt    = cnt_r;
    slice_nxt  = slice_r;
    ovalid_nxt = ovalid_r && !out_ready;
    rd_ok_nxt  = 1'b0;
    job_nxt    = job_r;
    rem_nxt    = rem_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    nwake_nxt  = nwake_r;
    okind_nxt  = okind_r;
    otid_nxt   = otid_r;
    opre_nxt   = opre_r;
    olast_nxt  = olast_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          job_nxt   = q_job;
          rem_nxt   = q_job.ticks;
          ptr_nxt   = '0;
          pos_nxt   = '0;
          nwake_nxt = '0;
          rd_ok_nxt = (q_job.cmd != CMD_SLEEP);
          okind_nxt = KIND_DISPATCH;
          otid_nxt  = '0;
          opre_nxt  = 1'b0;
          olast_nxt = 1'b1;
          if (q_job.cmd == CMD_SLEEP) begin
            if (q_job.ticks == 32'd0)            okind_nxt = KIND_IGNORED;
            else if (cnt_r == CW'(MAX_SLEEPERS)) okind_nxt = KIND_FULL;
            else                                 okind_nxt = KIND_QUEUED;
          end
          if (q_job.cmd == CMD_DISPATCH) slice_nxt = '0;
        end
      end
      ST_TICK_DEC: ptr_nxt = '0;
      ST_WAKE: begin
        if (!rd_ok_r) begin
          rd_ok_nxt = 1'b1;
        end else if (!ovalid_r || out_ready) begin
          if (cnt_r != '0 && rd_dl_r == 32'd0 && nwake_r != WW'(WakeLimit)) begin
            ovalid_nxt = 1'b1;
            okind_nxt  = KIND_WOKEN;
            otid_nxt   = rd_id_r;
            opre_nxt   = 1'b0;
            olast_nxt  = 1'b0;
            nwake_nxt  = nwake_r + WW'(1);
            cnt_nxt    = cnt_r - CW'(1);
            ptr_nxt    = ptr_r + CW'(1);
          end else begin
            pos_nxt = '0;
          end
        end
      end
      ST_SHIFT: begin
        if (job_r.cmd == CMD_SLEEP) begin
          if (!rd_ok_r) rd_ok_nxt = 1'b1;
          else if (ptr_r > pos_r) ptr_nxt = ptr_r - CW'(1);
          else begin cnt_nxt = cnt_r + CW'(1); slice_nxt = '0; end
        end else begin
          if (!rd_ok_r) rd_ok_nxt = 1'b1;
          else begin pos_nxt = pos_r + CW'(1); ptr_nxt = ptr_r + CW'(1); end
        end
      end
      ST_STATUS: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = KIND_TICK;
          otid_nxt   = '0;
          olast_nxt  = 1'b1;
          opre_nxt   = 1'b0;
          if (job_r.allow) begin
            if (slice_inc >= {1'b0, time_slice}) begin
              opre_nxt = 1'b1; slice_nxt = '0;
            end else begin
              slice_nxt = slice_inc[15:0];
            end
          end
        end
      end
      ST_SEARCH: begin
        if (!rd_ok_r) rd_ok_nxt = 1'b1;
        else if (ptr_r < cnt_r && rem_r > rd_dl_r) begin
          rem_nxt = rem_r - rd_dl_r; ptr_nxt = ptr_r + CW'(1);
        end else begin
          pos_nxt = ptr_r; ptr_nxt = cnt_r;
        end
      end
      ST_REPLY: begin
        if (!ovalid_r || out_ready) ovalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      slice_r  <= '0;
      ovalid_r <= 1'b0;
      rd_ok_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      slice_r  <= slice_nxt;
      ovalid_r <= ovalid_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    rem_r   <= rem_nxt;
    ptr_r   <= ptr_nxt;
    pos_r   <= pos_nxt;
    nwake_r <= nwake_nxt;
    okind_r <= okind_nxt;
    otid_r  <= otid_nxt;
    opre_r  <= opre_nxt;
    olast_r <= olast_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SLEEPERS)) else $error("sleeper count out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind))) else $error("result lost");
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> !out_valid) else $error("accepted with result pending");

endmodule

/* hdl/delta_sleep_queue_with_time_slice.sv */
// Delta list sleep queue with time slice: the top level.
// A dispatch, full or ignored sleep result goes through ST_REPLY and is then registered on the output.
// A sleep walks the delta list and shifts entries. A tick decrements a nonzero head delta, reports woken
// threads, compacts the remaining entries and ends with a tick result. One command is
// carried out at a time. Reset (rst_n low, synchronous) empties the store, clears the slice counter, sets time_slice to 2.
module delta_sleep_queue_with_time_slice
  import dsq_pkg::*;
#(
  parameter int MAX_SLEEPERS = MaxSleepersDef
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command[1:0], thread_id[5:2], sleep_ticks[37:6], allow_preempt[38]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // kind[2:0], woken_thread[6:3], preempt[7]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] time_slice_r;
  job_t        in_job, q_job;
  logic        q_valid, q_ready;
  logic [2:0]  kind;
  logic [3:0]  tid;
  logic        pre;

  assign cfg_ready = 1'b1;

  // Time slice register.
  always_ff @(posedge clk) begin
    if (!rst_n) time_slice_r <= TimeSliceReset;
    else if (cfg_valid) time_slice_r <= cfg_data;
  end

  assign in_job.cmd   = cmd_t'(s_axis_tdata[1:0]);
  assign in_job.tid   = s_axis_tdata[5:2];
  assign in_job.ticks = s_axis_tdata[37:6];
  assign in_job.allow = s_axis_tdata[38];

  dsq_front u_front (
    .clk, .rst_n,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_job,
    .q_valid, .q_ready, .q_job
  );

  dsq_back #(.MAX_SLEEPERS(MAX_SLEEPERS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .time_slice(time_slice_r),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_kind(kind), .out_tid(tid), .out_pre(pre), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {pre, tid, kind};

endmodule
